// File: design/tss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer switch supervisor package
// Shared types, register indexes and timing constants.
// ----------------------------------------------------------------------------
package tss_pkg;

    localparam logic [31:0] SWITCH_LOCKOUT_MS = 32'd10000;
    localparam logic [31:0] DATA_TIMEOUT_MS   = 32'd15000;
    localparam logic [31:0] ALERT_COOLDOWN_MS = 32'd60000;
    localparam logic [31:0] LOCK_TIMEOUT_MS   = 32'd90000;

    localparam int ALERT_CHANNELS = 4;

    localparam logic [1:0] CHAN_TRANSFER_GRID  = 2'd0;
    localparam logic [1:0] CHAN_TRANSFER_SOLAR = 2'd1;
    localparam logic [1:0] CHAN_GRID           = 2'd2;
    localparam logic [1:0] CHAN_BATTERY        = 2'd3;

    localparam int ALERT_BLIND_GRID    = 0;
    localparam int ALERT_OVERLOAD      = 1;
    localparam int ALERT_BACK_TO_SOLAR = 2;
    localparam int ALERT_GRID_LOST     = 3;
    localparam int ALERT_GRID_RESTORED = 4;
    localparam int ALERT_BATTERY_LOW   = 5;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SAMPLE,
        OP_LOCK_START,
        OP_LOCK_ABORT
    } op_t;

    typedef enum logic [2:0] {
        CFG_GRID_TRIP_LOAD,
        CFG_SOLAR_RETURN_LOAD,
        CFG_BLIND_TRIP_LOAD,
        CFG_GRID_VALID_VOLT,
        CFG_GRID_LOST_VOLT,
        CFG_GRID_RESTORE_VOLT,
        CFG_BATTERY_LOW_VOLT,
        CFG_BATTERY_RECOVER_VOLT
    } cfg_index_t;

    typedef struct packed {
        logic [15:0] grid_trip_load;
        logic [15:0] solar_return_load;
        logic [15:0] blind_trip_load;
        logic [11:0] grid_valid_volt;
        logic [11:0] grid_lost_volt;
        logic [11:0] grid_restore_volt;
        logic [12:0] battery_low_volt;
        logic [12:0] battery_recover_volt;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] now_ms;
        logic [15:0] load_watts;
        logic [11:0] grid_decivolts;
        logic [12:0] battery_centivolts;
    } item_t;

    typedef struct packed {
        logic        on_grid;
        logic        data_valid;
        logic        grid_lost_flag;
        logic        battery_low_flag;
        logic        update_locked;
        logic [5:0]  alert_mask;
    } result_t;

    typedef struct packed {
        logic                                relay_grid;
        logic                                valid_flag;
        logic                                grid_lost_state;
        logic                                battery_low_state;
        logic                                lock_active;
        logic                                sample_seen;
        logic [31:0]                         lock_start_ms;
        logic [31:0]                         last_sample_ms;
        logic [31:0]                         last_transfer_ms;
        logic [15:0]                         stored_load;
        logic [11:0]                         stored_grid;
        logic [12:0]                         stored_battery;
        logic [ALERT_CHANNELS-1:0][31:0]     alert_times_ms;
    } state_t;

endpackage

// File: design/tss_item_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer switch supervisor input channel
// Valid/ready channel that carries one input item.
// ----------------------------------------------------------------------------
interface tss_item_if;

    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [31:0] now_ms;
    logic [15:0] load_watts;
    logic [11:0] grid_decivolts;
    logic [12:0] battery_centivolts;

    modport source (
        output valid,
        output op,
        output now_ms,
        output load_watts,
        output grid_decivolts,
        output battery_centivolts,
        input  ready
    );

    modport sink (
        input  valid,
        input  op,
        input  now_ms,
        input  load_watts,
        input  grid_decivolts,
        input  battery_centivolts,
        output ready
    );

endinterface

// File: design/tss_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer switch supervisor result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface tss_result_if;

    logic       valid;
    logic       ready;
    logic       on_grid;
    logic       data_valid;
    logic       grid_lost_flag;
    logic       battery_low_flag;
    logic       update_locked;
    logic [5:0] alert_mask;

    modport source (
        output valid,
        output on_grid,
        output data_valid,
        output grid_lost_flag,
        output battery_low_flag,
        output update_locked,
        output alert_mask,
        input  ready
    );

    modport sink (
        input  valid,
        input  on_grid,
        input  data_valid,
        input  grid_lost_flag,
        input  battery_low_flag,
        input  update_locked,
        input  alert_mask,
        output ready
    );

endinterface

// File: design/tss_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer switch supervisor configuration registers
// Threshold register file with a plain write port.
// ----------------------------------------------------------------------------
module tss_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data,
    output tss_pkg::cfg_t       cfg
);

    tss_pkg::cfg_t cfg_reg;
    tss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (tss_pkg::cfg_index_t'(cfg_index))
                tss_pkg::CFG_GRID_TRIP_LOAD:       cfg_next.grid_trip_load       = cfg_data;
                tss_pkg::CFG_SOLAR_RETURN_LOAD:    cfg_next.solar_return_load    = cfg_data;
                tss_pkg::CFG_BLIND_TRIP_LOAD:      cfg_next.blind_trip_load      = cfg_data;
                tss_pkg::CFG_GRID_VALID_VOLT:      cfg_next.grid_valid_volt      = cfg_data[11:0];
                tss_pkg::CFG_GRID_LOST_VOLT:       cfg_next.grid_lost_volt       = cfg_data[11:0];
                tss_pkg::CFG_GRID_RESTORE_VOLT:    cfg_next.grid_restore_volt    = cfg_data[11:0];
                tss_pkg::CFG_BATTERY_LOW_VOLT:     cfg_next.battery_low_volt     = cfg_data[12:0];
                tss_pkg::CFG_BATTERY_RECOVER_VOLT: cfg_next.battery_recover_volt = cfg_data[12:0];
                default:                           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_trip_load       <= 16'd4500;
            cfg_reg.solar_return_load    <= 16'd3500;
            cfg_reg.blind_trip_load      <= 16'd2000;
            cfg_reg.grid_valid_volt      <= 12'd1900;
            cfg_reg.grid_lost_volt       <= 12'd1500;
            cfg_reg.grid_restore_volt    <= 12'd1800;
            cfg_reg.battery_low_volt     <= 13'd4600;
            cfg_reg.battery_recover_volt <= 13'd5000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/tss_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transfer switch supervisor decision logic
// Computes the next supervisor state and the result for one item.
// ----------------------------------------------------------------------------
module tss_eval (
    input  tss_pkg::item_t   item,
    input  tss_pkg::state_t  st,
    input  tss_pkg::cfg_t    cfg,
    output tss_pkg::state_t  st_next,
    output tss_pkg::result_t result
);

    logic [31:0]                              lock_age;
    logic [31:0]                              sample_age;
    logic [31:0]                              transfer_age;
    logic [tss_pkg::ALERT_CHANNELS-1:0][31:0] alert_age;
    logic [tss_pkg::ALERT_CHANNELS-1:0]       cool_ok;
    logic                                     lock_held;
    logic                                     run_item;
    logic                                     is_sample;
    logic [15:0]                              eff_load;
    logic [11:0]                              eff_grid;
    logic [12:0]                              eff_battery;
    logic [31:0]                              eff_last_sample;
    logic                                     timed_out;
    logic                                     valid_eff;
    logic                                     seen_eff;
    logic                                     lockout_ok;
    logic [5:0]                               alerts;

    assign lock_age  = item.now_ms - st.lock_start_ms;
    assign lock_held = (item.op != tss_pkg::OP_LOCK_ABORT) && st.lock_active
                       && !(lock_age > tss_pkg::LOCK_TIMEOUT_MS);
    assign run_item  = (item.op != tss_pkg::OP_LOCK_START) && !lock_held;
    assign is_sample = run_item && (item.op == tss_pkg::OP_SAMPLE);

    assign eff_load        = is_sample ? item.load_watts : st.stored_load;
    assign eff_grid        = is_sample ? item.grid_decivolts : st.stored_grid;
    assign eff_battery     = is_sample ? item.battery_centivolts : st.stored_battery;
    assign eff_last_sample = is_sample ? item.now_ms : st.last_sample_ms;

    assign sample_age   = item.now_ms - eff_last_sample;
    assign timed_out    = sample_age > tss_pkg::DATA_TIMEOUT_MS;
    assign valid_eff    = (st.valid_flag || is_sample) && !timed_out;
    assign seen_eff     = st.sample_seen || is_sample;
    assign transfer_age = item.now_ms - st.last_transfer_ms;
    assign lockout_ok   = transfer_age > tss_pkg::SWITCH_LOCKOUT_MS;

    for (genvar c = 0; c < tss_pkg::ALERT_CHANNELS; c++)
    begin : g_cool
        assign alert_age[c] = item.now_ms - st.alert_times_ms[c];
        assign cool_ok[c]   = alert_age[c] > tss_pkg::ALERT_COOLDOWN_MS;
    end

    always_comb
    begin
        st_next = st;
        alerts  = '0;
        if (item.op == tss_pkg::OP_LOCK_START)
        begin
            st_next.lock_active   = 1'b1;
            st_next.lock_start_ms = item.now_ms;
        end
        else
        begin
            st_next.lock_active = lock_held;
            if (run_item)
            begin
                if (is_sample)
                begin
                    st_next.stored_load    = item.load_watts;
                    st_next.stored_grid    = item.grid_decivolts;
                    st_next.stored_battery = item.battery_centivolts;
                    st_next.sample_seen    = 1'b1;
                    st_next.last_sample_ms = item.now_ms;
                end
                st_next.valid_flag = valid_eff;
                if (!valid_eff && seen_eff && timed_out)
                begin
                    if (!st.relay_grid && (eff_load > cfg.blind_trip_load))
                    begin
                        st_next.relay_grid       = 1'b1;
                        st_next.last_transfer_ms = item.now_ms;
                        if (cool_ok[tss_pkg::CHAN_TRANSFER_GRID])
                        begin
                            alerts[tss_pkg::ALERT_BLIND_GRID] = 1'b1;
                            st_next.alert_times_ms[tss_pkg::CHAN_TRANSFER_GRID] = item.now_ms;
                        end
                    end
                end
                else if (valid_eff)
                begin
                    if (lockout_ok)
                    begin
                        if ((eff_load > cfg.grid_trip_load) && !st.relay_grid
                            && (eff_grid > cfg.grid_valid_volt) && !st.grid_lost_state)
                        begin
                            st_next.relay_grid       = 1'b1;
                            st_next.last_transfer_ms = item.now_ms;
                            if (cool_ok[tss_pkg::CHAN_TRANSFER_GRID])
                            begin
                                alerts[tss_pkg::ALERT_OVERLOAD] = 1'b1;
                                st_next.alert_times_ms[tss_pkg::CHAN_TRANSFER_GRID] =
                                    item.now_ms;
                            end
                        end
                        else if ((eff_load < cfg.solar_return_load) && st.relay_grid)
                        begin
                            st_next.relay_grid       = 1'b0;
                            st_next.last_transfer_ms = item.now_ms;
                            if (cool_ok[tss_pkg::CHAN_TRANSFER_SOLAR])
                            begin
                                alerts[tss_pkg::ALERT_BACK_TO_SOLAR] = 1'b1;
                                st_next.alert_times_ms[tss_pkg::CHAN_TRANSFER_SOLAR] =
                                    item.now_ms;
                            end
                        end
                    end
                    if ((eff_grid < cfg.grid_lost_volt) && !st.grid_lost_state)
                    begin
                        st_next.grid_lost_state = 1'b1;
                        if (cool_ok[tss_pkg::CHAN_GRID])
                        begin
                            alerts[tss_pkg::ALERT_GRID_LOST] = 1'b1;
                            st_next.alert_times_ms[tss_pkg::CHAN_GRID] = item.now_ms;
                        end
                    end
                    else if ((eff_grid > cfg.grid_restore_volt) && st.grid_lost_state)
                    begin
                        st_next.grid_lost_state = 1'b0;
                        if (cool_ok[tss_pkg::CHAN_GRID])
                        begin
                            alerts[tss_pkg::ALERT_GRID_RESTORED] = 1'b1;
                            st_next.alert_times_ms[tss_pkg::CHAN_GRID] = item.now_ms;
                        end
                    end
                    if ((eff_battery <= cfg.battery_low_volt) && !st.battery_low_state)
                    begin
                        st_next.battery_low_state = 1'b1;
                        if (cool_ok[tss_pkg::CHAN_BATTERY])
                        begin
                            alerts[tss_pkg::ALERT_BATTERY_LOW] = 1'b1;
                            st_next.alert_times_ms[tss_pkg::CHAN_BATTERY] = item.now_ms;
                        end
                    end
                    else if ((eff_battery >= cfg.battery_recover_volt) && st.battery_low_state)
                    begin
                        st_next.battery_low_state = 1'b0;
                    end
                end
            end
        end
    end

    assign result.on_grid          = st_next.relay_grid;
    assign result.data_valid       = st_next.valid_flag;
    assign result.grid_lost_flag   = st_next.grid_lost_state;
    assign result.battery_low_flag = st_next.battery_low_state;
    assign result.update_locked    = st_next.lock_active;
    assign result.alert_mask       = alerts;

endmodule

// File: design/transfer_switch_supervisor_core.sv
`timescale 1ns / 1ps
// Flow: an accepted item waits in the input register and is then loaded into the result
// register, from which its result is offered.
// Throughput: one item per cycle while the result channel is ready; the supervisor state is
// updated in the same cycle that the result register is loaded, so the next item sees it at once.
// Reset: rst_n clears the supervisor state, loads the threshold defaults and empties both
// pipeline registers.
// ----------------------------------------------------------------------------
// Transfer switch supervisor core
// Solar/grid transfer relay supervisor with lock, watchdog and alert cooldown.
// ----------------------------------------------------------------------------
module transfer_switch_supervisor_core (
    input  logic           clk,
    input  logic           rst_n,
    tss_item_if.sink       req,
    tss_result_if.source   rsp,
    input  logic           cfg_we,
    input  logic [2:0]     cfg_index,
    input  logic [15:0]    cfg_data
);

    tss_pkg::cfg_t    cfg;
    tss_pkg::item_t   item_reg;
    tss_pkg::item_t   item_next;
    logic             item_valid_reg;
    tss_pkg::state_t  state_reg;
    tss_pkg::state_t  state_next;
    tss_pkg::result_t result_reg;
    tss_pkg::result_t result_next;
    logic             rsp_valid_reg;
    logic             advance;
    logic             take;

    tss_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tss_eval u_eval (
        .item    (item_reg),
        .st      (state_reg),
        .cfg     (cfg),
        .st_next (state_next),
        .result  (result_next)
    );

    assign advance   = item_valid_reg && (!rsp_valid_reg || rsp.ready);
    assign req.ready = !item_valid_reg || advance;
    assign take      = req.valid && req.ready;

    assign item_next.op                 = tss_pkg::op_t'(req.op);
    assign item_next.now_ms             = req.now_ms;
    assign item_next.load_watts         = req.load_watts;
    assign item_next.grid_decivolts     = req.grid_decivolts;
    assign item_next.battery_centivolts = req.battery_centivolts;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            state_reg      <= '0;
        end
        else
        begin
            if (take)
            begin
                item_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.on_grid          = result_reg.on_grid;
    assign rsp.data_valid       = result_reg.data_valid;
    assign rsp.grid_lost_flag   = result_reg.grid_lost_flag;
    assign rsp.battery_low_flag = result_reg.battery_low_flag;
    assign rsp.update_locked    = result_reg.update_locked;
    assign rsp.alert_mask       = result_reg.alert_mask;

    a_locked_no_alert : assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.update_locked |-> result_next.alert_mask == 6'd0)
        else $error("Alert raised by an item while the update lock is held.");

    a_one_grid_transfer : assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(result_next.alert_mask[tss_pkg::ALERT_BLIND_GRID]
                      && result_next.alert_mask[tss_pkg::ALERT_OVERLOAD]))
        else $error("Blind and overload transfers reported for one item.");

    a_solar_alert_relay : assert property (@(posedge clk) disable iff (!rst_n)
        advance && result_next.alert_mask[tss_pkg::ALERT_BACK_TO_SOLAR]
        |-> !result_next.on_grid && state_reg.relay_grid)
        else $error("Back-to-solar alert without a grid to solar transfer.");

    a_result_loaded : assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> rsp_valid_reg && state_reg == $past(state_next))
        else $error("Result register or state not loaded when an item advanced.");

endmodule
